// ----- rtl/imc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and sizes for the im2col patch extractor.
// No dependencies; every other rtl file imports this package.
package imc_pkg;

	localparam int MAX_HEIGHT   = 64;
	localparam int MAX_WIDTH    = 64;
	localparam int MAX_CHANNELS = 16;
	localparam int MAX_KERNEL   = 8;
	localparam int VALUE_BITS   = 16;

	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CHAN_W = $clog2(MAX_CHANNELS);
	localparam int ADDR_W = ROW_W + COL_W + CHAN_W;
	localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;

	localparam int POS_W  = 6;
	localparam int DIM_W  = 7;
	localparam int KDIM_W = 4;
	localparam int KIDX_W = 3;
	localparam int PAD_W  = 3;
	localparam int STEP_W = 4;
	localparam int DATA_W = 16;
	localparam int BASE_W = POS_W + STEP_W;
	localparam int ORG_W  = BASE_W + 1;

	typedef struct packed {
		logic [DIM_W-1:0]  image_height;
		logic [DIM_W-1:0]  image_width;
		logic [KDIM_W-1:0] kernel_height;
		logic [KDIM_W-1:0] kernel_width;
		logic [PAD_W-1:0]  pad_rows;
		logic [PAD_W-1:0]  pad_cols;
		logic [STEP_W-1:0] step_rows;
		logic [STEP_W-1:0] step_cols;
	} cfg_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] tap_value;
		logic                     in_padding;
		logic [KIDX_W-1:0]        tap_row;
		logic [KIDX_W-1:0]        tap_col;
		logic                     last;
		logic                     bad_request;
	} res_t;

endpackage

// ----- rtl/imc_pixel_store.sv -----
`timescale 1ns / 1ps
// Pixel store: one write port, one read port with registered read data.
// Depends on imc_pkg for depth and widths.
module imc_pixel_store (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [imc_pkg::ADDR_W-1:0]       wr_addr,
	input  logic [imc_pkg::VALUE_BITS-1:0]   wr_data,
	input  logic                             rd_en,
	input  logic [imc_pkg::ADDR_W-1:0]       rd_addr,
	output logic [imc_pkg::VALUE_BITS-1:0]   rd_data
);
	import imc_pkg::*;

	logic [VALUE_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/imc_tap_seq.sv -----
`timescale 1ns / 1ps
// Patch sequencer: window check, tap walk over one shared address unit,
// read stage and result register. Depends on imc_pkg.
module imc_tap_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  imc_pkg::cfg_t                  cfg,
	input  logic                           req_go,
	input  logic [imc_pkg::POS_W-1:0]      req_row,
	input  logic [imc_pkg::POS_W-1:0]      req_col,
	input  logic [imc_pkg::CHAN_W-1:0]     req_chan,
	output logic                           busy,
	output logic                           rd_en,
	output logic [imc_pkg::ADDR_W-1:0]     rd_addr,
	input  logic [imc_pkg::VALUE_BITS-1:0] rd_data,
	output imc_pkg::res_t                  res
);
	import imc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_RUN
	} state_t;

	state_t                   state_q;
	logic [BASE_W-1:0]        base_row_q;
	logic [BASE_W-1:0]        base_col_q;
	logic [CHAN_W-1:0]        chan_q;
	logic signed [ORG_W-1:0]  row_org_q;
	logic signed [ORG_W-1:0]  col_org_q;
	logic [KIDX_W-1:0]        fh_q;
	logic [KIDX_W-1:0]        fw_q;
	logic                     valid_s1;
	logic                     inside_s1;
	logic [KIDX_W-1:0]        fh_s1;
	logic [KIDX_W-1:0]        fw_s1;
	logic                     last_s1;
	res_t                     res_q;

	logic                     kernel_bad;
	logic                     window_bad;
	logic [ORG_W-1:0]         row_need;
	logic [ORG_W-1:0]         row_lim;
	logic [ORG_W-1:0]         col_need;
	logic [ORG_W-1:0]         col_lim;
	logic signed [ORG_W-1:0]  tap_r;
	logic signed [ORG_W-1:0]  tap_c;
	logic                     in_image;
	logic                     row_end;
	logic                     last_tap;

	always_comb begin
		kernel_bad = (cfg.kernel_height == '0) || (cfg.kernel_width == '0) ||
			(cfg.kernel_height > KDIM_W'(MAX_KERNEL)) ||
			(cfg.kernel_width > KDIM_W'(MAX_KERNEL));
		row_need = ORG_W'(base_row_q) + ORG_W'(cfg.kernel_height);
		row_lim  = ORG_W'(cfg.image_height) + ORG_W'({cfg.pad_rows, 1'b0});
		col_need = ORG_W'(base_col_q) + ORG_W'(cfg.kernel_width);
		col_lim  = ORG_W'(cfg.image_width) + ORG_W'({cfg.pad_cols, 1'b0});
		window_bad = (row_need > row_lim) || (col_need > col_lim);

		tap_r = row_org_q + $signed({{(ORG_W-KIDX_W){1'b0}}, fh_q});
		tap_c = col_org_q + $signed({{(ORG_W-KIDX_W){1'b0}}, fw_q});
		in_image = !tap_r[ORG_W-1] && !tap_c[ORG_W-1] &&
			(tap_r[ORG_W-2:0] < (ORG_W-1)'(cfg.image_height)) &&
			(tap_c[ORG_W-2:0] < (ORG_W-1)'(cfg.image_width));
		row_end  = (KDIM_W'(fw_q) + KDIM_W'(1)) == cfg.kernel_width;
		last_tap = row_end && ((KDIM_W'(fh_q) + KDIM_W'(1)) == cfg.kernel_height);
	end

	assign busy    = (state_q != S_IDLE);
	assign rd_en   = (state_q == S_RUN) && in_image;
	assign rd_addr = {tap_r[ROW_W-1:0], tap_c[COL_W-1:0], chan_q};
	assign res     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_s1 <= 1'b0;
			res_q    <= '0;
		end else begin
			res_q.valid <= 1'b0;
			valid_s1    <= (state_q == S_RUN);
			inside_s1   <= in_image;
			fh_s1       <= fh_q;
			fw_s1       <= fw_q;
			last_s1     <= last_tap;

			unique case (state_q)
				S_IDLE: begin
					if (req_go) begin
						base_row_q <= BASE_W'(req_row) * BASE_W'(cfg.step_rows);
						base_col_q <= BASE_W'(req_col) * BASE_W'(cfg.step_cols);
						chan_q     <= req_chan;
						state_q    <= S_CHECK;
					end
				end
				S_CHECK: begin
					row_org_q <= $signed(ORG_W'(base_row_q)) - $signed(ORG_W'(cfg.pad_rows));
					col_org_q <= $signed(ORG_W'(base_col_q)) - $signed(ORG_W'(cfg.pad_cols));
					fh_q      <= '0;
					fw_q      <= '0;
					if (kernel_bad || window_bad) begin
						res_q.valid       <= 1'b1;
						res_q.tap_value   <= '0;
						res_q.in_padding  <= 1'b0;
						res_q.tap_row     <= '0;
						res_q.tap_col     <= '0;
						res_q.last        <= 1'b1;
						res_q.bad_request <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (row_end) begin
						fw_q <= '0;
						fh_q <= fh_q + KIDX_W'(1);
					end else begin
						fw_q <= fw_q + KIDX_W'(1);
					end
					if (last_tap) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (valid_s1) begin
				res_q.valid       <= 1'b1;
				res_q.tap_value   <= inside_s1 ? DATA_W'($signed(rd_data)) : '0;
				res_q.in_padding  <= !inside_s1;
				res_q.tap_row     <= fh_s1;
				res_q.tap_col     <= fw_s1;
				res_q.last        <= last_s1;
				res_q.bad_request <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/im2col_patch_extractor.sv -----
`timescale 1ns / 1ps
// im2col patch extractor, top level: configuration registers, pixel writes,
// pixel store and patch sequencer. Depends on imc_pkg, imc_pixel_store, imc_tap_seq.
// Write: accepted while idle, busy stays low, no result.
// Request: busy through one check state, then one tap per cycle through the single store
// read port (a rejected request ends after the check state). Each tap passes the store
// read register, the read stage and the result register on its way to the ports; a rejected
// request's one result is set straight into the result register. A new start waits for busy low.
// Reset clears control and restores register defaults; the pixel store is not cleared.
// Every result is shown for one cycle on result_valid; the receiver cannot stall.
module im2col_patch_extractor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic [imc_pkg::POS_W-1:0]         pos_row,
	input  logic [imc_pkg::POS_W-1:0]         pos_col,
	input  logic [imc_pkg::CHAN_W-1:0]        chan,
	input  logic signed [imc_pkg::DATA_W-1:0] pixel_in,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [imc_pkg::DIM_W-1:0]         cfg_data,
	output logic                              result_valid,
	output logic signed [imc_pkg::DATA_W-1:0] tap_value,
	output logic                              in_padding,
	output logic [imc_pkg::KIDX_W-1:0]        tap_row,
	output logic [imc_pkg::KIDX_W-1:0]        tap_col,
	output logic                              last,
	output logic                              bad_request
);
	import imc_pkg::*;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd0;
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
	localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd2;
	localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd3;
	localparam logic [2:0] REG_PAD_ROWS      = 3'd4;
	localparam logic [2:0] REG_PAD_COLS      = 3'd5;
	localparam logic [2:0] REG_STEP_ROWS     = 3'd6;
	localparam logic [2:0] REG_STEP_COLS     = 3'd7;

	cfg_t                  cfg_q;
	cfg_t                  cfg;
	logic                  accept;
	logic                  wr_en;
	logic                  req_go;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [VALUE_BITS-1:0] rd_data;
	res_t                  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_height  <= DIM_W'(32);
			cfg_q.image_width   <= DIM_W'(32);
			cfg_q.kernel_height <= KDIM_W'(3);
			cfg_q.kernel_width  <= KDIM_W'(3);
			cfg_q.pad_rows      <= PAD_W'(1);
			cfg_q.pad_cols      <= PAD_W'(1);
			cfg_q.step_rows     <= STEP_W'(1);
			cfg_q.step_cols     <= STEP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data;
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data;
				REG_KERNEL_HEIGHT: cfg_q.kernel_height <= cfg_data[KDIM_W-1:0];
				REG_KERNEL_WIDTH:  cfg_q.kernel_width  <= cfg_data[KDIM_W-1:0];
				REG_PAD_ROWS:      cfg_q.pad_rows      <= cfg_data[PAD_W-1:0];
				REG_PAD_COLS:      cfg_q.pad_cols      <= cfg_data[PAD_W-1:0];
				REG_STEP_ROWS:     cfg_q.step_rows     <= cfg_data[STEP_W-1:0];
				REG_STEP_COLS:     cfg_q.step_cols     <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg = cfg_q;
		if (cfg_q.image_height > DIM_W'(MAX_HEIGHT)) begin
			cfg.image_height = DIM_W'(MAX_HEIGHT);
		end
		if (cfg_q.image_width > DIM_W'(MAX_WIDTH)) begin
			cfg.image_width = DIM_W'(MAX_WIDTH);
		end
	end

	assign accept = start && !busy;
	assign req_go = accept && (opcode == OP_REQUEST);
	assign wr_en  = accept && (opcode == OP_WRITE) &&
		(DIM_W'(pos_row) < cfg.image_height) && (DIM_W'(pos_col) < cfg.image_width);

	imc_pixel_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr ({pos_row[ROW_W-1:0], pos_col[COL_W-1:0], chan}),
		.wr_data (VALUE_BITS'(pixel_in)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	imc_tap_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.req_go   (req_go),
		.req_row  (pos_row),
		.req_col  (pos_col),
		.req_chan (chan),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res      (res)
	);

	assign result_valid = res.valid;
	assign tap_value    = res.tap_value;
	assign in_padding   = res.in_padding;
	assign tap_row      = res.tap_row;
	assign tap_col      = res.tap_col;
	assign last         = res.last;
	assign bad_request  = res.bad_request;

endmodule

// ----- sim/im2col_patch_extractor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for im2col_patch_extractor: directed and random pixel writes and
// patch requests, each tap checked against an in-bench image store and window walker.
// Depends on imc_pkg and the rtl top level im2col_patch_extractor.
module im2col_patch_extractor_tb;
	import imc_pkg::*;

	typedef enum logic {OP_WRITE = 1'b0, OP_PATCH = 1'b1} op_e;

	typedef enum logic [2:0] {
		REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH, REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH,
		REG_PAD_ROWS, REG_PAD_COLS, REG_STEP_ROWS, REG_STEP_COLS
	} shape_reg_e;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              pad;
		logic [KIDX_W-1:0] row;
		logic [KIDX_W-1:0] col;
		logic              last;
		logic              bad;
	} tap_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     opcode;
	logic [POS_W-1:0]         pos_row;
	logic [POS_W-1:0]         pos_col;
	logic [CHAN_W-1:0]        chan;
	logic signed [DATA_W-1:0] pixel_in;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [2:0]               cfg_index;
	logic [DIM_W-1:0]         cfg_data;
	logic                     result_valid;
	logic signed [DATA_W-1:0] tap_value;
	logic                     in_padding;
	logic [KIDX_W-1:0]        tap_row;
	logic [KIDX_W-1:0]        tap_col;
	logic                     last;
	logic                     bad_request;

	int                shape [8];
	logic [DATA_W-1:0] image_mem [DEPTH];
	bit                image_set [DEPTH];
	tap_t              taps_due [$];
	int                errors = 0;
	bit                gaps_on = 1'b0;
	int                items_sent = 0;

	im2col_patch_extractor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.pos_row      (pos_row),
		.pos_col      (pos_col),
		.chan         (chan),
		.pixel_in     (pixel_in),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.tap_value    (tap_value),
		.in_padding   (in_padding),
		.tap_row      (tap_row),
		.tap_col      (tap_col),
		.last         (last),
		.bad_request  (bad_request)
	);

	always #6 clk = ~clk;

	function automatic int rows_in_use();
		return (shape[REG_IMAGE_HEIGHT] > MAX_HEIGHT) ? MAX_HEIGHT : shape[REG_IMAGE_HEIGHT];
	endfunction

	function automatic int cols_in_use();
		return (shape[REG_IMAGE_WIDTH] > MAX_WIDTH) ? MAX_WIDTH : shape[REG_IMAGE_WIDTH];
	endfunction

	function automatic int pixel_addr(int row, int col, int ch);
		return (row * MAX_WIDTH + col) * MAX_CHANNELS + ch;
	endfunction

	function automatic int image_row(int prow, int fh);
		return prow * shape[REG_STEP_ROWS] + fh - shape[REG_PAD_ROWS];
	endfunction

	function automatic int image_col(int pcol, int fw);
		return pcol * shape[REG_STEP_COLS] + fw - shape[REG_PAD_COLS];
	endfunction

	function automatic bit inside_image(int r, int c);
		return r >= 0 && c >= 0 && r < rows_in_use() && c < cols_in_use();
	endfunction

	function automatic bit window_fits(int prow, int pcol);
		int kh;
		int kw;
		kh = shape[REG_KERNEL_HEIGHT];
		kw = shape[REG_KERNEL_WIDTH];
		return kh != 0 && kw != 0 && kh <= MAX_KERNEL && kw <= MAX_KERNEL
			&& prow * shape[REG_STEP_ROWS] + kh <= rows_in_use() + 2 * shape[REG_PAD_ROWS]
			&& pcol * shape[REG_STEP_COLS] + kw <= cols_in_use() + 2 * shape[REG_PAD_COLS];
	endfunction

	function automatic void store_pixel(int row, int col, int ch, logic [DATA_W-1:0] v);
		if (row < rows_in_use() && col < cols_in_use()) begin
			image_mem[pixel_addr(row, col, ch)] = v;
			image_set[pixel_addr(row, col, ch)] = 1'b1;
		end
	endfunction

	function automatic void predict_patch(int prow, int pcol, int ch);
		tap_t t;
		int r;
		int c;
		int kh;
		int kw;
		kh = shape[REG_KERNEL_HEIGHT];
		kw = shape[REG_KERNEL_WIDTH];
		if (!window_fits(prow, pcol)) begin
			t = '0;
			t.last = 1'b1;
			t.bad = 1'b1;
			taps_due.push_back(t);
			return;
		end
		for (int fh = 0; fh < kh; fh++) begin
			for (int fw = 0; fw < kw; fw++) begin
				r = image_row(prow, fh);
				c = image_col(pcol, fw);
				t = '0;
				t.pad = !inside_image(r, c);
				if (!t.pad) begin
					t.value = image_mem[pixel_addr(r, c, ch)];
				end
				t.row = KIDX_W'(fh);
				t.col = KIDX_W'(fw);
				t.last = (fh == kh - 1) && (fw == kw - 1);
				taps_due.push_back(t);
			end
		end
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : tap_check
		tap_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (taps_due.size() == 0) begin
				$error("unexpected tap: tap_value %0h, bad_request %0b", tap_value, bad_request);
				errors++;
			end else begin
				want = taps_due.pop_front();
				check_field("tap_value", want.value, tap_value);
				check_field("in_padding", DATA_W'(want.pad), DATA_W'(in_padding));
				check_field("tap_row", DATA_W'(want.row), DATA_W'(tap_row));
				check_field("tap_col", DATA_W'(want.col), DATA_W'(tap_col));
				check_field("last", DATA_W'(want.last), DATA_W'(last));
				check_field("bad_request", DATA_W'(want.bad), DATA_W'(bad_request));
			end
		end
	end

	task automatic send_item(op_e op, int row, int col, int ch, logic [DATA_W-1:0] pix);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		pos_row <= POS_W'(row);
		pos_col <= POS_W'(col);
		chan <= CHAN_W'(ch);
		pixel_in <= pix;
		do @(posedge clk); while (busy);
		items_sent++;
		if (op == OP_WRITE) begin
			store_pixel(row, col, ch, pix);
		end else begin
			predict_patch(row, col, ch);
		end
	endtask

	task automatic release_start();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic settle();
		release_start();
		while (taps_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(shape_reg_e idx, int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(val);
		do @(posedge clk); while (!cfg_ready);
		shape[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_shape(int ih, int iw, int kh, int kw, int pr, int pc, int sr, int sc);
		settle();
		write_reg(REG_IMAGE_HEIGHT, ih);
		write_reg(REG_IMAGE_WIDTH, iw);
		write_reg(REG_KERNEL_HEIGHT, kh);
		write_reg(REG_KERNEL_WIDTH, kw);
		write_reg(REG_PAD_ROWS, pr);
		write_reg(REG_PAD_COLS, pc);
		write_reg(REG_STEP_ROWS, sr);
		write_reg(REG_STEP_COLS, sc);
	endtask

	// write every unwritten pixel the window reads, so no tap sees an empty entry
	task automatic request_patch(int prow, int pcol, int ch);
		int r;
		int c;
		if (window_fits(prow, pcol)) begin
			for (int fh = 0; fh < shape[REG_KERNEL_HEIGHT]; fh++) begin
				for (int fw = 0; fw < shape[REG_KERNEL_WIDTH]; fw++) begin
					r = image_row(prow, fh);
					c = image_col(pcol, fw);
					if (inside_image(r, c) && !image_set[pixel_addr(r, c, ch)]) begin
						send_item(OP_WRITE, r, c, ch, DATA_W'($urandom));
					end
				end
			end
		end
		send_item(OP_PATCH, prow, pcol, ch, DATA_W'($urandom));
	endtask

	task automatic test_reset_shape();
		request_patch(0, 0, 0);
		request_patch(32, 0, 3);
	endtask

	task automatic test_extreme_values();
		set_shape(64, 64, 1, 1, 0, 0, 1, 1);
		send_item(OP_WRITE, 63, 63, 15, 16'h8000);
		send_item(OP_WRITE, 0, 0, 0, 16'h7fff);
		request_patch(63, 63, 15);
		request_patch(0, 0, 0);
	endtask

	task automatic test_ignored_writes();
		set_shape(4, 4, 1, 1, 0, 0, 1, 1);
		send_item(OP_WRITE, 63, 63, 15, 16'h1234);
		send_item(OP_WRITE, 4, 2, 7, 16'h5555);
		set_shape(64, 64, 1, 1, 0, 0, 1, 1);
		request_patch(63, 63, 15);
	endtask

	task automatic test_large_kernel();
		set_shape(64, 64, 8, 8, 7, 7, 8, 8);
		request_patch(0, 0, 5);
		request_patch(9, 0, 5);
		request_patch(0, 9, 5);
	endtask

	task automatic test_kernel_rejects();
		set_shape(64, 64, 0, 3, 0, 0, 1, 1);
		request_patch(0, 0, 0);
		set_shape(64, 64, 15, 12, 0, 0, 1, 1);
		request_patch(0, 0, 0);
	endtask

	task automatic test_degenerate_image();
		set_shape(0, 5, 2, 2, 1, 1, 1, 1);
		request_patch(0, 0, 1);
		set_shape(5, 0, 2, 2, 1, 1, 1, 1);
		request_patch(0, 0, 1);
		set_shape(127, 100, 1, 1, 0, 0, 2, 2);
		request_patch(31, 31, 15);
		request_patch(32, 0, 15);
	endtask

	task automatic test_zero_stride();
		set_shape(8, 8, 2, 2, 0, 0, 0, 0);
		request_patch(63, 63, 2);
		request_patch(0, 0, 2);
	endtask

	function automatic int pick_dim(int maxv);
		case ($urandom_range(0, 19))
			0: return 0;
			1: return $urandom_range(maxv + 1, 127);
			2: return maxv;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_kernel();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return $urandom_range(MAX_KERNEL + 1, 15);
			2: return MAX_KERNEL;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic int pick_pad();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
	endfunction

	function automatic int pick_step();
		case ($urandom_range(0, 11))
			0: return 0;
			1: return $urandom_range(9, 15);
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	function automatic int pick_pos(int room, int step);
		if (room < 0 || step == 0 || $urandom_range(0, 7) == 0) begin
			return $urandom_range(0, 63);
		end
		return $urandom_range(0, (room / step > 63) ? 63 : room / step);
	endfunction

	task automatic random_op();
		int row;
		int col;
		int kind;
		kind = $urandom_range(0, 19);
		if (kind < 12) begin
			row = pick_pos(rows_in_use() + 2 * shape[REG_PAD_ROWS] - shape[REG_KERNEL_HEIGHT],
				shape[REG_STEP_ROWS]);
			col = pick_pos(cols_in_use() + 2 * shape[REG_PAD_COLS] - shape[REG_KERNEL_WIDTH],
				shape[REG_STEP_COLS]);
			request_patch(row, col, $urandom_range(0, MAX_CHANNELS - 1));
		end else if (kind < 18 && rows_in_use() > 0 && cols_in_use() > 0) begin
			send_item(OP_WRITE, $urandom_range(0, rows_in_use() - 1),
				$urandom_range(0, cols_in_use() - 1), $urandom_range(0, MAX_CHANNELS - 1),
				DATA_W'($urandom));
		end else begin
			send_item(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, MAX_CHANNELS - 1), DATA_W'($urandom));
		end
	endtask

	task automatic test_random_traffic();
		while (items_sent < 360) begin
			set_shape(pick_dim(MAX_HEIGHT), pick_dim(MAX_WIDTH), pick_kernel(), pick_kernel(),
				pick_pad(), pick_pad(), pick_step(), pick_step());
			gaps_on = (items_sent < 300) && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < 40 && items_sent < 360; n++) begin
				random_op();
			end
		end
		gaps_on = 1'b0;
	endtask

	initial begin
		shape = '{32, 32, 3, 3, 1, 1, 1, 1};
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_WRITE;
		pos_row = '0;
		pos_col = '0;
		chan = '0;
		pixel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_HEIGHT;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		gaps_on = 1'b1;
		test_reset_shape();
		test_extreme_values();
		test_ignored_writes();
		test_large_kernel();
		test_kernel_rejects();
		test_degenerate_image();
		test_zero_stride();
		test_random_traffic();
		settle();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
